FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RMS decimator back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: cond holds, then prop holds in the same cycle.
`define RMSD_ASSERT_IMPL(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rmsd assertion failed");

// Next-cycle implication: cond holds, then prop holds in the next cycle.
`define RMSD_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rmsd assertion failed");

`endif

FILE: hw/rtl/rmsd_pkg.sv
// Package: types and constants of the block RMS decimator.
`default_nettype none
package rmsd_pkg;
    localparam int TIME_BITS   = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_BLOCK   = 256;
    localparam int CNT_BITS    = 9;
    localparam int TSUM_BITS   = 40;
    localparam int VSUM_BITS   = 25;
    localparam int SQSUM_BITS  = 39;
    localparam int MAG_BITS    = 24;
    localparam int NN_BITS     = 17;
    localparam int DIV_BITS    = 48;
    localparam int SQ_BITS     = 32;
    localparam int SQ_STEPS    = SQ_BITS / 2;

    typedef struct packed {
        logic [TIME_BITS-1:0]          sample_time;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } sample_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   mean_time;
        logic [SAMPLE_BITS-1:0] rms_value;
    } result_t;

    // One closed block handed from front to back.
    typedef struct packed {
        logic [CNT_BITS-1:0]         n;
        logic [TSUM_BITS-1:0]        tsum;
        logic signed [VSUM_BITS-1:0] vsum;
        logic [SQSUM_BITS-1:0]       sqsum;
    } block_t;
endpackage
`default_nettype wire

FILE: hw/rtl/rmsd_front.sv
// Front end: block size register and per-sample accumulation.
`default_nettype none
module rmsd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    input  wire logic [rmsd_pkg::CNT_BITS-1:0] cfg_data,
    input  wire logic                          accept,
    input  wire rmsd_pkg::sample_t             sample,
    output rmsd_pkg::block_t                   push_data,
    output logic                               push
);
    logic [rmsd_pkg::CNT_BITS-1:0]         block_size_reg;
    logic [rmsd_pkg::CNT_BITS-1:0]         count_reg, count_next, n_eff;
    logic [rmsd_pkg::TSUM_BITS-1:0]        tsum_reg, tsum_next;
    logic signed [rmsd_pkg::VSUM_BITS-1:0] vsum_reg, vsum_next;
    logic [rmsd_pkg::SQSUM_BITS-1:0]       sqsum_reg, sqsum_next;
    logic signed [2*rmsd_pkg::SAMPLE_BITS-1:0] sq;
    logic close;

    always_comb
    begin
        if (block_size_reg == '0)
            n_eff = rmsd_pkg::CNT_BITS'(1);
        else if (block_size_reg > rmsd_pkg::CNT_BITS'(rmsd_pkg::MAX_BLOCK))
            n_eff = rmsd_pkg::CNT_BITS'(rmsd_pkg::MAX_BLOCK);
        else
            n_eff = block_size_reg;
        sq         = sample.sample_value * sample.sample_value;
        count_next = count_reg + rmsd_pkg::CNT_BITS'(1);
        tsum_next  = tsum_reg + rmsd_pkg::TSUM_BITS'(sample.sample_time);
        vsum_next  = vsum_reg + rmsd_pkg::VSUM_BITS'(sample.sample_value);
        sqsum_next = sqsum_reg + rmsd_pkg::SQSUM_BITS'($unsigned(sq));
        close      = (count_next >= n_eff);
        push       = accept && close;
        push_data.n     = count_next;
        push_data.tsum  = tsum_next;
        push_data.vsum  = vsum_next;
        push_data.sqsum = sqsum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= rmsd_pkg::CNT_BITS'(2);
            count_reg      <= '0;
            tsum_reg       <= '0;
            vsum_reg       <= '0;
            sqsum_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
                block_size_reg <= cfg_data;
            if (accept)
            begin
                if (close)
                begin
                    count_reg <= '0;
                    tsum_reg  <= '0;
                    vsum_reg  <= '0;
                    sqsum_reg <= '0;
                end
                else
                begin
                    count_reg <= count_next;
                    tsum_reg  <= tsum_next;
                    vsum_reg  <= vsum_next;
                    sqsum_reg <= sqsum_next;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/rmsd_fifo.sv
// Two-entry queue of closed blocks between front and back.
`default_nettype none
module rmsd_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire rmsd_pkg::block_t push_data,
    input  wire logic             pop,
    output rmsd_pkg::block_t      head,
    output logic                  empty,
    output logic                  full
);
    rmsd_pkg::block_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/rmsd_back.sv
// Back end: variance numerator, serial divisions, integer root, result register.
`default_nettype none
`include "assert_macros.svh"
module rmsd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rmsd_pkg::block_t head,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output rmsd_pkg::result_t     result_data
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIFF = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam int DSTEP_BITS = $clog2(rmsd_pkg::DIV_BITS);
    localparam int SSTEP_BITS = $clog2(rmsd_pkg::SQ_STEPS);
    localparam int RT_BITS    = rmsd_pkg::CNT_BITS + 1;
    localparam int RV_BITS    = rmsd_pkg::NN_BITS + 1;

    logic [2:0] state_reg;
    rmsd_pkg::block_t blk_reg;
    logic [rmsd_pkg::DIV_BITS-1:0] prod1_reg, prod2_reg, vdiv_reg, tdiv_reg;
    logic [rmsd_pkg::NN_BITS-1:0]  nn_reg;
    logic [RV_BITS-1:0]            rv_reg;
    logic [RT_BITS-1:0]            rt_reg;
    logic [DSTEP_BITS-1:0]         dstep_reg;
    logic [SSTEP_BITS-1:0]         sstep_reg;
    logic [rmsd_pkg::SQ_BITS-1:0]  sv_reg, sr_reg, sbit_reg;
    logic [rmsd_pkg::SQ_BITS-1:0]  sv_next, sr_next;
    rmsd_pkg::result_t             result_reg;
    logic                          result_valid_reg;

    logic [rmsd_pkg::MAG_BITS-1:0]  mag;
    logic signed [rmsd_pkg::VSUM_BITS-1:0] vneg;
    logic [RV_BITS-1:0]  rv_sh, rv_next;
    logic [RT_BITS-1:0]  rt_sh, rt_next;
    logic                qv, qt;
    logic [rmsd_pkg::SQ_BITS-1:0] trial;

    always_comb
    begin
        vneg = -blk_reg.vsum;
        mag  = blk_reg.vsum[rmsd_pkg::VSUM_BITS-1] ?
               rmsd_pkg::MAG_BITS'(vneg) : rmsd_pkg::MAG_BITS'(blk_reg.vsum);
        // one restoring step of each division
        rv_sh   = {rv_reg[RV_BITS-2:0], vdiv_reg[rmsd_pkg::DIV_BITS-1]};
        qv      = (rv_sh >= RV_BITS'(nn_reg));
        rv_next = qv ? rv_sh - RV_BITS'(nn_reg) : rv_sh;
        rt_sh   = {rt_reg[RT_BITS-2:0], tdiv_reg[rmsd_pkg::DIV_BITS-1]};
        qt      = (rt_sh >= RT_BITS'(blk_reg.n));
        rt_next = qt ? rt_sh - RT_BITS'(blk_reg.n) : rt_sh;
        // one digit of the root
        trial = sr_reg + sbit_reg;
        if (sv_reg >= trial)
        begin
            sv_next = sv_reg - trial;
            sr_next = (sr_reg >> 1) + sbit_reg;
        end
        else
        begin
            sv_next = sv_reg;
            sr_next = sr_reg >> 1;
        end
        pop = (state_reg == S_IDLE) && !empty;
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (!empty)
                    blk_reg <= head;
            S_MUL:
            begin
                prod1_reg <= rmsd_pkg::DIV_BITS'(blk_reg.n)
                             * rmsd_pkg::DIV_BITS'(blk_reg.sqsum);
                prod2_reg <= rmsd_pkg::DIV_BITS'(mag) * rmsd_pkg::DIV_BITS'(mag);
                tdiv_reg  <= rmsd_pkg::DIV_BITS'(blk_reg.tsum);
            end
            S_DIFF:
            begin
                vdiv_reg <= prod1_reg - prod2_reg;
                nn_reg   <= rmsd_pkg::NN_BITS'(blk_reg.n) * rmsd_pkg::NN_BITS'(blk_reg.n);
                rv_reg   <= '0;
                rt_reg   <= '0;
            end
            S_DIV:
            begin
                vdiv_reg <= {vdiv_reg[rmsd_pkg::DIV_BITS-2:0], qv};
                tdiv_reg <= {tdiv_reg[rmsd_pkg::DIV_BITS-2:0], qt};
                rv_reg   <= rv_next;
                rt_reg   <= rt_next;
                if (dstep_reg == DSTEP_BITS'(rmsd_pkg::DIV_BITS - 1))
                begin
                    sv_reg   <= {vdiv_reg[rmsd_pkg::SQ_BITS-2:0], qv};
                    sr_reg   <= '0;
                    sbit_reg <= rmsd_pkg::SQ_BITS'(1) << (rmsd_pkg::SQ_BITS - 2);
                end
            end
            S_SQRT:
            begin
                sv_reg   <= sv_next;
                sr_reg   <= sr_next;
                sbit_reg <= sbit_reg >> 2;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_DONE && !(result_valid_reg && result_stall))
        begin
            result_reg.mean_time <= tdiv_reg[rmsd_pkg::TIME_BITS-1:0];
            result_reg.rms_value <= sr_reg[rmsd_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            dstep_reg        <= '0;
            sstep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result replaces the one taken at this edge
            if (state_reg == S_DONE && !(result_valid_reg && result_stall))
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (!empty)
                        state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_DIFF;
                S_DIFF:
                begin
                    dstep_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    dstep_reg <= dstep_reg + DSTEP_BITS'(1);
                    if (dstep_reg == DSTEP_BITS'(rmsd_pkg::DIV_BITS - 1))
                    begin
                        sstep_reg <= '0;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    sstep_reg <= sstep_reg + SSTEP_BITS'(1);
                    if (sstep_reg == SSTEP_BITS'(rmsd_pkg::SQ_STEPS - 1))
                        state_reg <= S_DONE;
                end
                S_DONE:
                    if (!(result_valid_reg && result_stall))
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    `RMSD_ASSERT_IMPL(a_pop_idle, pop, state_reg == S_IDLE)
    `RMSD_ASSERT_NEXT(a_done_holds, state_reg == S_DONE && result_valid_reg && result_stall,
                      state_reg == S_DONE)
    `RMSD_ASSERT_IMPL(a_div_range, state_reg == S_DIV,
                      dstep_reg <= DSTEP_BITS'(rmsd_pkg::DIV_BITS - 1))
endmodule
`default_nettype wire

FILE: hw/rtl/block_rms_decimator.sv
// Top level of the block RMS decimator: front, block queue and back end.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  sample    | sample_valid/_stall    | sample_data  (time, signed value)
//  result    | result_valid/_stall    | result_data  (mean time, rms)
//  config    | cfg_valid/cfg_ready    | cfg_data     (block size)
//
// Samples are taken one per cycle; sample_stall rises only when the
// two-entry block queue is full. The back end works on one closed block
// at a time, in order: pop, two products, difference, two 48-step
// restoring dividers run side by side for time and variance, a 16-step
// root, result load; with small blocks that loop sets the sustained rate;
// a stalled result holds the back end in its last state. Reset clears all
// accumulators and sets size to 2.
`default_nettype none
module block_rms_decimator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire rmsd_pkg::sample_t             sample_data,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output rmsd_pkg::result_t                  result_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rmsd_pkg::CNT_BITS-1:0] cfg_data
);
    rmsd_pkg::block_t push_data, head;
    logic push, pop, empty, full, accept;

    // the queue full flag alone throttles input
    assign sample_stall = full;
    assign accept       = sample_valid && !full;
    assign cfg_ready    = 1'b1;

    rmsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sample    (sample_data),
        .push_data (push_data),
        .push      (push)
    );

    rmsd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    rmsd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );
endmodule
`default_nettype wire
